// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mwmo_pkg.sv =====
`default_nettype none
package mwmo_pkg;

	localparam int TABLE_SIZE_DEF = 2048;
	localparam int MIP_LEVELS_DEF = 8;
	localparam int NUM_TABLES_DEF = 8;

	localparam int PHASE_W = 32;
	localparam int FRAC_BITS = 21;
	localparam int WHOLE_W = PHASE_W - FRAC_BITS;
	localparam int MORPH_W = 16;
	localparam int FREQ_W = 24;
	localparam int SEL_W = 3;
	localparam int LEVEL_W = 3;
	localparam int INDEX_W = 11;
	localparam int SAMPLE_W = 16;
	localparam int SR_W = 18;
	localparam int MASK_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 18;
	localparam int FADE_W = 8;
	localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

	// Shift of the fixed-point reciprocal used for the index wrap.
	localparam int RECIP_SHIFT = 26;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_RATE = 1'b0,
		REG_READY_MASK  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		FUNC_RENDER = 1'b0,
		FUNC_WRITE  = 1'b1
	} func_t;

	// Load enables of the pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_load_t;

	// Offset of a mip level inside one table's slot.
	function automatic int level_base(input int ts, input int m);
		int off;
		off = 0;
		for (int k = 0; k < m; k++) begin
			off += ts >> k;
		end
		return off;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mwmo_wave_ram.sv =====
`default_nettype none
module mwmo_wave_ram #(
	parameter int DEPTH = 2 * mwmo_pkg::TABLE_SIZE_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [AW-1:0]                       waddr,
	input  wire logic signed [mwmo_pkg::SAMPLE_W-1:0] wdata,
	input  wire logic                                re,
	input  wire logic [AW-1:0]                       raddr0,
	input  wire logic [AW-1:0]                       raddr1,
	output logic signed [mwmo_pkg::SAMPLE_W-1:0]      rdata0,
	output logic signed [mwmo_pkg::SAMPLE_W-1:0]      rdata1
);

	logic signed [mwmo_pkg::SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mwmo_front.sv =====
`default_nettype none
module mwmo_front #(
	parameter int TABLE_SIZE = mwmo_pkg::TABLE_SIZE_DEF,
	parameter int MIP_LEVELS = mwmo_pkg::MIP_LEVELS_DEF,
	parameter int NUM_TABLES = mwmo_pkg::NUM_TABLES_DEF,
	parameter int LVL_W = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1,
	parameter int TAB_W = $clog2(NUM_TABLES),
	parameter int AW = $clog2(2 * TABLE_SIZE)
) (
	input  wire logic                                  clk,
	input  wire mwmo_pkg::stage_load_t                 load,
	input  wire logic                                  func,
	input  wire logic [mwmo_pkg::PHASE_W-1:0]          phase,
	input  wire logic signed [mwmo_pkg::MORPH_W-1:0]   morph,
	input  wire logic [mwmo_pkg::FREQ_W-1:0]           frequency,
	input  wire logic [mwmo_pkg::SEL_W-1:0]            table_select,
	input  wire logic [mwmo_pkg::LEVEL_W-1:0]          level,
	input  wire logic [mwmo_pkg::INDEX_W-1:0]          index,
	input  wire logic signed [mwmo_pkg::SAMPLE_W-1:0]  word,
	input  wire logic [mwmo_pkg::SR_W-1:0]             sample_rate,
	input  wire logic [mwmo_pkg::MASK_W-1:0]           ready_mask,
	output logic                                       render_s3,
	output logic                                       wen_s3,
	output logic [TAB_W-1:0]                           wtab_s3,
	output logic [AW-1:0]                              waddr_s3,
	output logic signed [mwmo_pkg::SAMPLE_W-1:0]       word_s3,
	output logic [AW-1:0]                              raddr0,
	output logic [AW-1:0]                              raddr1,
	output logic [TAB_W-1:0]                           a_s3,
	output logic [TAB_W-1:0]                           b_s3,
	output logic [mwmo_pkg::FADE_W-1:0]                f_s3,
	output logic [mwmo_pkg::FRAC_BITS-1:0]             r_s3,
	output logic                                       ra_s3,
	output logic                                       rb_s3,
	output logic                                       zero_s3
);

	localparam int LVL_N = 1 << LVL_W;
	localparam int WR_N = 1 << mwmo_pkg::LEVEL_W;
	localparam int SIZE_W = $clog2(TABLE_SIZE + 1);
	localparam int RECIP_W = mwmo_pkg::RECIP_SHIFT + 1;
	localparam int HIT_W = mwmo_pkg::FREQ_W + 1 + SIZE_W + 1;
	localparam int WW = mwmo_pkg::WHOLE_W;
	localparam int PROD_W = WW + RECIP_W;
	localparam int QS_W = WW + SIZE_W;
	localparam int SUM_W = ((AW > WW) ? AW : WW) + 2;
	localparam int MW = TAB_W + mwmo_pkg::FADE_W;
	localparam int MAX_MORPH = (NUM_TABLES - 1) * 256;
	localparam int CMP_W = 16;

	// Per-level constants, selected by the level that is in flight.
	logic [SIZE_W-1:0]  lvl_size [LVL_N];
	logic [AW-1:0]      lvl_base [LVL_N];
	logic [RECIP_W-1:0] lvl_recip [LVL_N];
	logic [SIZE_W-1:0]  wr_size [WR_N];
	logic [AW-1:0]      wr_base [WR_N];
	logic [LVL_N-1:0]   hit;

	// Stage 1: the accepted word.
	mwmo_pkg::func_t                      func_s1;
	logic [mwmo_pkg::PHASE_W-1:0]         phase_s1;
	logic signed [mwmo_pkg::MORPH_W-1:0]  morph_s1;
	logic [mwmo_pkg::FREQ_W-1:0]          frequency_s1;
	logic [mwmo_pkg::SEL_W-1:0]           tsel_s1;
	logic [mwmo_pkg::LEVEL_W-1:0]         level_s1;
	logic [mwmo_pkg::INDEX_W-1:0]         index_s1;
	logic signed [mwmo_pkg::SAMPLE_W-1:0] word_s1;

	logic [LVL_W-1:0]       lvl_c;
	logic [MW-1:0]          clamp_c;
	logic [TAB_W-1:0]       a_c;
	logic [TAB_W-1:0]       b_c;
	logic [NUM_TABLES-1:0]  rdy_c;
	logic                   wok_c;

	// Stage 2.
	logic                                 render_s2;
	logic [LVL_W-1:0]                     lvl_s2;
	logic [mwmo_pkg::PHASE_W-1:0]         phase_s2;
	logic [TAB_W-1:0]                     a_s2;
	logic [TAB_W-1:0]                     b_s2;
	logic [mwmo_pkg::FADE_W-1:0]          f_s2;
	logic                                 ra_s2;
	logic                                 rb_s2;
	logic                                 wen_s2;
	logic [TAB_W-1:0]                     wtab_s2;
	logic [AW-1:0]                        waddr_s2;
	logic signed [mwmo_pkg::SAMPLE_W-1:0] word_s2;

	logic [mwmo_pkg::PHASE_W-1:0] shifted_c;
	logic [PROD_W-1:0]            prod_c;

	// Stage 3.
	logic [LVL_W-1:0] lvl_s3;
	logic [WW-1:0]    v_s3;
	logic [WW-1:0]    q_s3;

	logic [QS_W-1:0] qs_c;
	logic [WW-1:0]   i0_c;
	logic [WW:0]     nxt_c;
	logic [WW:0]     i1_c;

	for (genvar m = 0; m < LVL_N; m++) begin : g_lvl
		localparam int SZ = (m < MIP_LEVELS) ? (TABLE_SIZE >> m) : 0;
		localparam int BS = mwmo_pkg::level_base(TABLE_SIZE, (m < MIP_LEVELS) ? m : 0);
		localparam longint RC =
			(SZ == 0) ? 0 : ((longint'(1) << mwmo_pkg::RECIP_SHIFT) + SZ - 1) / SZ;
		assign lvl_size[m] = SIZE_W'(SZ);
		assign lvl_base[m] = AW'(BS);
		assign lvl_recip[m] = RECIP_W'(RC);
		assign hit[m] = (HIT_W'({frequency_s1, 1'b0}) * HIT_W'(lvl_size[m]))
			>= HIT_W'({sample_rate, 8'd0});
	end

	for (genvar w = 0; w < WR_N; w++) begin : g_wr
		localparam int WSZ = (w < MIP_LEVELS) ? (TABLE_SIZE >> w) : 0;
		localparam int WBS = mwmo_pkg::level_base(TABLE_SIZE, (w < MIP_LEVELS) ? w : 0);
		assign wr_size[w] = SIZE_W'(WSZ);
		assign wr_base[w] = AW'(WBS);
	end

	always_ff @(posedge clk) begin
		if (load.s1) begin
			func_s1 <= mwmo_pkg::func_t'(func);
			phase_s1 <= phase;
			morph_s1 <= morph;
			frequency_s1 <= frequency;
			tsel_s1 <= table_select;
			level_s1 <= level;
			index_s1 <= index;
			word_s1 <= word;
		end
	end

	// Mip level: the lowest level whose band still reaches the sample rate, else the top; 0 at zero frequency.
	always_comb begin
		lvl_c = LVL_W'(MIP_LEVELS - 1);
		for (int m = MIP_LEVELS - 2; m >= 0; m--) begin
			if (hit[m]) begin
				lvl_c = LVL_W'(m);
			end
		end
		if (frequency_s1 == '0) begin
			lvl_c = '0;
		end
	end

	always_comb begin
		if (morph_s1[mwmo_pkg::MORPH_W-1]) begin
			clamp_c = '0;
		end else if (morph_s1[mwmo_pkg::MORPH_W-2:0] > (mwmo_pkg::MORPH_W-1)'(MAX_MORPH)) begin
			clamp_c = MW'(MAX_MORPH);
		end else begin
			clamp_c = morph_s1[MW-1:0];
		end
		a_c = clamp_c[MW-1:mwmo_pkg::FADE_W];
		b_c = (a_c == TAB_W'(NUM_TABLES - 1)) ? '0 : a_c + 1'b1;
		rdy_c = ready_mask[NUM_TABLES-1:0];
		wok_c = (func_s1 == mwmo_pkg::FUNC_WRITE)
			&& (CMP_W'(tsel_s1) < CMP_W'(NUM_TABLES))
			&& (CMP_W'(index_s1) < CMP_W'(wr_size[level_s1]));
	end

	always_ff @(posedge clk) begin
		if (load.s2) begin
			render_s2 <= (func_s1 == mwmo_pkg::FUNC_RENDER);
			lvl_s2 <= lvl_c;
			phase_s2 <= phase_s1;
			a_s2 <= a_c;
			b_s2 <= b_c;
			f_s2 <= clamp_c[mwmo_pkg::FADE_W-1:0];
			ra_s2 <= rdy_c[a_c];
			rb_s2 <= rdy_c[b_c];
			wen_s2 <= wok_c;
			wtab_s2 <= tsel_s1[TAB_W-1:0];
			waddr_s2 <= AW'(SUM_W'(wr_base[level_s1]) + SUM_W'(index_s1));
			word_s2 <= word_s1;
		end
	end

	// The whole part of the shifted phase is divided by the level size
	// through a reciprocal; the quotient is exact for any whole part.
	always_comb begin
		shifted_c = phase_s2 >> lvl_s2;
		prod_c = PROD_W'(shifted_c[mwmo_pkg::PHASE_W-1:mwmo_pkg::FRAC_BITS])
			* PROD_W'(lvl_recip[lvl_s2]);
	end

	always_ff @(posedge clk) begin
		if (load.s3) begin
			render_s3 <= render_s2;
			lvl_s3 <= lvl_s2;
			v_s3 <= shifted_c[mwmo_pkg::PHASE_W-1:mwmo_pkg::FRAC_BITS];
			r_s3 <= shifted_c[mwmo_pkg::FRAC_BITS-1:0];
			q_s3 <= prod_c[mwmo_pkg::RECIP_SHIFT +: WW];
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			f_s3 <= f_s2;
			ra_s3 <= ra_s2;
			rb_s3 <= rb_s2;
			wen_s3 <= wen_s2;
			wtab_s3 <= wtab_s2;
			waddr_s3 <= waddr_s2;
			word_s3 <= word_s2;
		end
	end

	always_comb begin
		qs_c = QS_W'(q_s3) * QS_W'(lvl_size[lvl_s3]);
		i0_c = v_s3 - qs_c[WW-1:0];
		nxt_c = {1'b0, i0_c} + 1'b1;
		i1_c = (QS_W'(nxt_c) == QS_W'(lvl_size[lvl_s3])) ? '0 : nxt_c;
		zero_s3 = (lvl_size[lvl_s3] == '0);
		if (zero_s3) begin
			raddr0 = '0;
			raddr1 = '0;
		end else begin
			raddr0 = AW'(SUM_W'(lvl_base[lvl_s3]) + SUM_W'(i0_c));
			raddr1 = AW'(SUM_W'(lvl_base[lvl_s3]) + SUM_W'(i1_c));
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mwmo_blend.sv =====
`default_nettype none
module mwmo_blend #(
	parameter int NUM_TABLES = mwmo_pkg::NUM_TABLES_DEF,
	parameter int TAB_W = $clog2(NUM_TABLES)
) (
	input  wire logic                                 clk,
	input  wire mwmo_pkg::stage_load_t                load,
	input  wire logic signed [mwmo_pkg::SAMPLE_W-1:0] rd0 [NUM_TABLES],
	input  wire logic signed [mwmo_pkg::SAMPLE_W-1:0] rd1 [NUM_TABLES],
	input  wire logic [TAB_W-1:0]                     a_s3,
	input  wire logic [TAB_W-1:0]                     b_s3,
	input  wire logic [mwmo_pkg::FADE_W-1:0]          f_s3,
	input  wire logic [mwmo_pkg::FRAC_BITS-1:0]       r_s3,
	input  wire logic                                 ra_s3,
	input  wire logic                                 rb_s3,
	input  wire logic                                 zero_s3,
	output logic signed [mwmo_pkg::SAMPLE_W-1:0]      sample
);

	localparam int SW = mwmo_pkg::SAMPLE_W;
	localparam int FB = mwmo_pkg::FRAC_BITS;
	localparam int LW = SW + FB + 2;
	localparam int XW = SW + mwmo_pkg::FADE_W + 3;
	localparam logic signed [XW-1:0] XF_ROUND = XW'(128);
	localparam logic signed [LW-1:0] LERP_ROUND = LW'(longint'(1) << (FB - 1));

	logic [TAB_W-1:0]            a_s4;
	logic [TAB_W-1:0]            b_s4;
	logic [mwmo_pkg::FADE_W-1:0] f_s4;
	logic [FB-1:0]               r_s4;
	logic                        ra_s4;
	logic                        rb_s4;
	logic                        zero_s4;
	logic signed [SW-1:0]        sa_c;
	logic signed [SW-1:0]        sb_c;

	logic signed [SW-1:0]        sa_s5;
	logic signed [SW-1:0]        sb_s5;
	logic [mwmo_pkg::FADE_W-1:0] f_s5;
	logic signed [SW:0]          diff_c;
	logic signed [XW-1:0]        acc_c;
	logic signed [XW-9:0]        y_c;
	logic signed [SW-1:0]        sat_c;

	logic signed [SW-1:0]        sample_s6;

	// Linear interpolation between two neighbor words, rounded half up.
	function automatic logic signed [SW-1:0] lerp(
		input logic signed [SW-1:0] s0,
		input logic signed [SW-1:0] s1,
		input logic [FB-1:0]        r
	);
		logic signed [SW:0]   d;
		logic signed [LW-1:0] acc;
		d = (SW+1)'(s1) - (SW+1)'(s0);
		acc = (LW'(s0) <<< FB) + LW'(d) * LW'($signed({1'b0, r})) + LERP_ROUND;
		return acc[FB +: SW];
	endfunction

	always_ff @(posedge clk) begin
		if (load.s4) begin
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			f_s4 <= f_s3;
			r_s4 <= r_s3;
			ra_s4 <= ra_s3;
			rb_s4 <= rb_s3;
			zero_s4 <= zero_s3;
		end
	end

	always_comb begin
		sa_c = (ra_s4 && !zero_s4) ? lerp(rd0[a_s4], rd1[a_s4], r_s4) : '0;
		sb_c = (rb_s4 && !zero_s4) ? lerp(rd0[b_s4], rd1[b_s4], r_s4) : '0;
	end

	always_ff @(posedge clk) begin
		if (load.s5) begin
			sa_s5 <= sa_c;
			sb_s5 <= sb_c;
			f_s5 <= f_s4;
		end
	end

	// Crossfade written as sa*256 + f*(sb - sa), so one multiply per sample.
	always_comb begin
		diff_c = (SW+1)'(sb_s5) - (SW+1)'(sa_s5);
		acc_c = (XW'(sa_s5) <<< 8) + XW'(diff_c) * XW'($signed({1'b0, f_s5})) + XF_ROUND;
		y_c = acc_c[XW-1:8];
		if (y_c > (XW-8)'(32767)) begin
			sat_c = 16'sh7FFF;
		end else if (y_c < -(XW-8)'(32768)) begin
			sat_c = 16'sh8000;
		end else begin
			sat_c = y_c[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load.s6) begin
			sample_s6 <= sat_c;
		end
	end

	assign sample = sample_s6;

endmodule
`default_nettype wire

// ===== rtl/core/mipmapped_wavetable_morph_oscillator_unit.sv =====
// A render word moves through stages s1 to s6 and shows on out_valid from the s6 register.
// Throughput: one word per cycle, render or write, when out_ready does not stall it; write words give no result.
// The six stages hold their word under back-pressure and close up bubbles.
// Reset clears the pipeline, sets sample_rate to 48000 and ready_mask to 0.
// Table memory is not cleared; every entry must be written before it is read.
`default_nettype none
`include "assert_macros.svh"
module mipmapped_wavetable_morph_oscillator_unit #(
	parameter int TABLE_SIZE = mwmo_pkg::TABLE_SIZE_DEF,
	parameter int MIP_LEVELS = mwmo_pkg::MIP_LEVELS_DEF,
	parameter int NUM_TABLES = mwmo_pkg::NUM_TABLES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [mwmo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mwmo_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 func,
	input  wire logic [mwmo_pkg::PHASE_W-1:0]         phase,
	input  wire logic signed [mwmo_pkg::MORPH_W-1:0]  morph,
	input  wire logic [mwmo_pkg::FREQ_W-1:0]          frequency,
	input  wire logic [mwmo_pkg::SEL_W-1:0]           table_select,
	input  wire logic [mwmo_pkg::LEVEL_W-1:0]         level,
	input  wire logic [mwmo_pkg::INDEX_W-1:0]         index,
	input  wire logic signed [mwmo_pkg::SAMPLE_W-1:0] word,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [mwmo_pkg::SAMPLE_W-1:0]      sample
);

	localparam int LVL_W = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
	localparam int TAB_W = $clog2(NUM_TABLES);
	localparam int DEPTH = 2 * TABLE_SIZE;
	localparam int AW = $clog2(DEPTH);

	logic [mwmo_pkg::SR_W-1:0]   sample_rate_q;
	logic [mwmo_pkg::MASK_W-1:0] ready_mask_q;

	mwmo_pkg::stage_load_t load;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic valid_s6;

	logic                                 render_s3;
	logic                                 wen_s3;
	logic [TAB_W-1:0]                     wtab_s3;
	logic [AW-1:0]                        waddr_s3;
	logic signed [mwmo_pkg::SAMPLE_W-1:0] word_s3;
	logic [AW-1:0]                        raddr0;
	logic [AW-1:0]                        raddr1;
	logic [TAB_W-1:0]                     a_s3;
	logic [TAB_W-1:0]                     b_s3;
	logic [mwmo_pkg::FADE_W-1:0]          f_s3;
	logic [mwmo_pkg::FRAC_BITS-1:0]       r_s3;
	logic                                 ra_s3;
	logic                                 rb_s3;
	logic                                 zero_s3;

	logic [NUM_TABLES-1:0]                we_vec;
	logic signed [mwmo_pkg::SAMPLE_W-1:0] rd0 [NUM_TABLES];
	logic signed [mwmo_pkg::SAMPLE_W-1:0] rd1 [NUM_TABLES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= mwmo_pkg::SR_RESET;
			ready_mask_q <= '0;
		end else if (cfg_write) begin
			unique case (mwmo_pkg::cfg_reg_t'(cfg_index))
				mwmo_pkg::REG_SAMPLE_RATE: begin
					sample_rate_q <= cfg_data[mwmo_pkg::SR_W-1:0];
				end
				mwmo_pkg::REG_READY_MASK: begin
					ready_mask_q <= cfg_data[mwmo_pkg::MASK_W-1:0];
				end
			endcase
		end
	end

	// A stage loads when it is empty or its word moves on.
	always_comb begin
		load.s6 = !valid_s6 || out_ready;
		load.s5 = !valid_s5 || load.s6;
		load.s4 = !valid_s4 || load.s5;
		load.s3 = !valid_s3 || load.s4;
		load.s2 = !valid_s2 || load.s3;
		load.s1 = !valid_s1 || load.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (load.s1) begin
				valid_s1 <= in_valid;
			end
			if (load.s2) begin
				valid_s2 <= valid_s1;
			end
			if (load.s3) begin
				valid_s3 <= valid_s2;
			end
			// Write words are done once they pass the memory stage.
			if (load.s4) begin
				valid_s4 <= valid_s3 && render_s3;
			end
			if (load.s5) begin
				valid_s5 <= valid_s4;
			end
			if (load.s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	assign in_ready = load.s1;
	assign out_valid = valid_s6;

	mwmo_front #(
		.TABLE_SIZE(TABLE_SIZE),
		.MIP_LEVELS(MIP_LEVELS),
		.NUM_TABLES(NUM_TABLES),
		.LVL_W(LVL_W),
		.TAB_W(TAB_W),
		.AW(AW)
	) u_front (
		.clk(clk),
		.load(load),
		.func(func),
		.phase(phase),
		.morph(morph),
		.frequency(frequency),
		.table_select(table_select),
		.level(level),
		.index(index),
		.word(word),
		.sample_rate(sample_rate_q),
		.ready_mask(ready_mask_q),
		.render_s3(render_s3),
		.wen_s3(wen_s3),
		.wtab_s3(wtab_s3),
		.waddr_s3(waddr_s3),
		.word_s3(word_s3),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.a_s3(a_s3),
		.b_s3(b_s3),
		.f_s3(f_s3),
		.r_s3(r_s3),
		.ra_s3(ra_s3),
		.rb_s3(rb_s3),
		.zero_s3(zero_s3)
	);

	// One memory per table, so both morph tables are read in the same cycle.
	// Writes and reads share stage 3, which keeps them in word order.
	for (genvar t = 0; t < NUM_TABLES; t++) begin : g_table
		assign we_vec[t] = valid_s3 && wen_s3 && load.s4 && (wtab_s3 == TAB_W'(t));

		mwmo_wave_ram #(
			.DEPTH(DEPTH),
			.AW(AW)
		) u_ram (
			.clk(clk),
			.we(we_vec[t]),
			.waddr(waddr_s3),
			.wdata(word_s3),
			.re(load.s4),
			.raddr0(raddr0),
			.raddr1(raddr1),
			.rdata0(rd0[t]),
			.rdata1(rd1[t])
		);
	end

	mwmo_blend #(
		.NUM_TABLES(NUM_TABLES),
		.TAB_W(TAB_W)
	) u_blend (
		.clk(clk),
		.load(load),
		.rd0(rd0),
		.rd1(rd1),
		.a_s3(a_s3),
		.b_s3(b_s3),
		.f_s3(f_s3),
		.r_s3(r_s3),
		.ra_s3(ra_s3),
		.rb_s3(rb_s3),
		.zero_s3(zero_s3),
		.sample(sample)
	);

	`ASSERT_IMPL(a_empty_ready, clk, arst_n, !out_valid, in_ready, "ready low with empty output")
	`ASSERT_NEXT(a_accept_s1, clk, arst_n, in_valid && in_ready, valid_s1, "accepted word lost")
	`ASSERT_NEXT(a_write_drop, clk, arst_n, valid_s3 && !render_s3 && load.s4, !valid_s4, "write word passed memory stage")
	`ASSERT_IMPL(a_one_write, clk, arst_n, 1'b1, $onehot0(we_vec), "more than one table written")

endmodule
`default_nettype wire
